### src/mur2_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mur2_pkg
// Shared types and constants for the streaming 32-bit MurmurHash2 block.
// ----------------------------------------------------------------------------
package mur2_pkg;

   typedef logic [31:0] word_type;
   typedef logic [2:0]  count_type;

   localparam word_type MIX_MUL     = 32'h5bd1_e995;
   localparam int       MIX_SHIFT   = 24;
   localparam int       FIN_SHIFT_A = 13;
   localparam int       FIN_SHIFT_B = 15;
   localparam word_type SEED_RESET  = 32'd5381;

   // Byte mask for a partial tail word; zero for empty and full words.
   function automatic word_type tail_mask(input count_type count);
      word_type mask;
      begin
         case (count)
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            3'd3:    mask = 32'h00ff_ffff;
            default: mask = '0;
         endcase
         return mask;
      end
   endfunction

endpackage

### src/mur2_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mur2_mul
// Shared multiplier by the mix constant, low 32 bits, registered product.
// ----------------------------------------------------------------------------
module mur2_mul (
   input  logic              clock,
   input  logic              enable,
   input  mur2_pkg::word_type operand,
   output mur2_pkg::word_type product
);
   import mur2_pkg::*;

   word_type product_ff;
   word_type product_in;

   assign product_in = word_type'(operand * MIX_MUL);

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

### src/murmur2_hash32_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur2_hash32_top
// Streaming 32-bit MurmurHash2 over a key delivered as 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_*): one key word per request, first byte in bits
//    7:0. req_first loads the hash with seed ^ req_key_length; req_last
//    closes the key and produces one response. req_byte_count is 4 for full
//    words, 1..3 for a tail, 0 for an empty key.
//  - Response channel (rsp_*): one hash per request marked last.
//  - CSR channel (csr_*): writes the seed; always ready. Write only while
//    the block is idle.
//  - Timing: all products come from one registered 32x32 multiplier by the
//    mix constant, so the multiplier sets the rate. A full word passes
//    through accept and states K1, K2, K3, a tail through accept and T1, an
//    empty word through accept alone. A request marked last adds states F1
//    and F2 before the hash is registered on rsp_hash_value.
//  - Stall: the response sits in an output register; the next key can be
//    accepted while it waits. A second finished hash waits in the final
//    state (req_stall high) until the output register frees up.
//  - Reset (synchronous): seed returns to 5381, accumulator to zero, no
//    response pending.
// ----------------------------------------------------------------------------
module murmur2_hash32_top (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  mur2_pkg::word_type  req_key_word,
   input  mur2_pkg::count_type req_byte_count,
   input  mur2_pkg::word_type  req_key_length,
   input  logic                req_first,
   input  logic                req_last,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mur2_pkg::word_type  rsp_hash_value,
   // seed register
   input  logic                csr_valid,
   output logic                csr_ready,
   input  mur2_pkg::word_type  csr_seed
);
   import mur2_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;  // accept; multiply accumulator
   localparam logic [2:0] S_K1   = 3'd1;  // store acc*M; multiply word
   localparam logic [2:0] S_K2   = 3'd2;  // multiply k ^ k>>24
   localparam logic [2:0] S_K3   = 3'd3;  // acc ^= k
   localparam logic [2:0] S_T1   = 3'd4;  // store tail product
   localparam logic [2:0] S_F1   = 3'd5;  // multiply h ^ h>>13
   localparam logic [2:0] S_F2   = 3'd6;  // h ^ h>>15 to output register

   logic [2:0] state_ff, state_in;
   word_type   seed_ff, seed_in;
   word_type   acc_ff, acc_in;
   word_type   word_ff, word_in;
   logic       last_ff, last_in;
   logic       rsp_valid_ff, rsp_valid_in;
   word_type   rsp_hash_ff, rsp_hash_in;

   logic       req_accept;
   logic       rsp_take;
   logic       out_free;
   word_type   acc_load;
   word_type   mul_operand;
   word_type   mul_product;
   logic       mul_enable;

   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

   assign seed_in  = (csr_valid && csr_ready) ? csr_seed : seed_ff;
   assign acc_load = req_first ? (seed_ff ^ req_key_length) : acc_ff;

   mur2_mul u_mul (
      .clock   (clock),
      .enable  (mul_enable),
      .operand (mul_operand),
      .product (mul_product)
   );

   // sequencer and multiplier operand select
   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      word_in      = word_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_take ? 1'b0 : rsp_valid_ff;
      rsp_hash_in  = rsp_hash_ff;
      mul_operand  = acc_ff;
      mul_enable   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            // tail words fold the masked bytes in before the multiply
            mul_operand = acc_load ^ (req_key_word & tail_mask(req_byte_count));
            if (req_accept) begin
               mul_enable = 1'b1;
               acc_in     = acc_load;
               word_in    = req_key_word;
               last_in    = req_last;
               if (req_byte_count[2]) begin
                  state_in = S_K1;
               end else if (req_byte_count != '0) begin
                  state_in = S_T1;
               end else if (req_last) begin
                  state_in = S_F1;
               end
            end
         end
         S_K1: begin
            acc_in      = mul_product;
            mul_operand = word_ff;
            mul_enable  = 1'b1;
            state_in    = S_K2;
         end
         S_K2: begin
            mul_operand = mul_product ^ (mul_product >> MIX_SHIFT);
            mul_enable  = 1'b1;
            state_in    = S_K3;
         end
         S_K3: begin
            acc_in   = acc_ff ^ mul_product;
            state_in = last_ff ? S_F1 : S_IDLE;
         end
         S_T1: begin
            acc_in   = mul_product;
            state_in = last_ff ? S_F1 : S_IDLE;
         end
         S_F1: begin
            mul_operand = acc_ff ^ (acc_ff >> FIN_SHIFT_A);
            mul_enable  = 1'b1;
            state_in    = S_F2;
         end
         S_F2: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = mul_product ^ (mul_product >> FIN_SHIFT_B);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seed_ff      <= SEED_RESET;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      last_ff     <= last_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   // an empty word that does not close the key leaves the block ready
   a_empty_quick: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_byte_count == '0 && !req_last) |=> !req_stall)
      else $error("empty word did not return to idle");

   // a full word that does not close the key returns to idle after K1, K2 and K3
   a_full_rate: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_byte_count[2] && !req_last) |-> ##4 !req_stall)
      else $error("full word sequence length wrong");

   // a new response only appears out of the final state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_F2)
      else $error("response raised outside final state");

   // a finished hash waits while the output register is occupied
   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_F2 && rsp_valid_ff && rsp_stall) |=> state_ff == S_F2)
      else $error("finished hash dropped while output stalled");

endmodule
